// ===== design/sbusdf_pkg.sv =====
// sbusdf_pkg: shared constants, result codes and the result record of the deframer
// used by sbus_channel_deframer and sbusdf_checker; depends on nothing else

package sbusdf_pkg;

	localparam int CHANNEL_COUNT = 16;

	localparam logic [7:0] HEADER_RESET = 8'h0F;
	localparam logic [4:0] POS_IDLE     = 5'd25;
	localparam logic [4:0] POS_HEADER   = 5'd0;
	localparam logic [4:0] POS_FLAGS    = 5'd23;
	localparam logic [4:0] CH_BITS      = 5'd11;
	localparam logic [4:0] BYTE_BITS    = 5'd8;
	localparam int         ACC_W        = 18;
	localparam int         VAL_W        = 11;
	localparam int         FLAG_LOST    = 2;
	localparam int         FLAG_FS      = 3;

	localparam logic [1:0] KIND_CHANNEL = 2'd0;
	localparam logic [1:0] KIND_STATUS  = 2'd1;
	localparam logic [1:0] KIND_BAD_HDR = 2'd2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [3:0]       channel_index;
		logic [VAL_W-1:0] channel_value;
		logic             frame_lost;
		logic             failsafe;
		logic             last;
	} result_t;

endpackage

// ===== design/sbus_channel_deframer.sv =====
// sbus_channel_deframer: per-byte frame decoder, one beat in, at most one result beat out
// a result beat is registered: it lands in the result register, or in the skid while the output is held
// throughput: one byte per cycle; a two-deep output (result register plus skid) keeps
// input and output apart, in_stall rises only when both are full
// reset: asynchronous active-low arst_n idles the frame position and empties the output
// depends on sbusdf_pkg

module sbus_channel_deframer import sbusdf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [7:0]             cfg_data,
	// byte input
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             data_byte,
	input  logic                   frame_start,
	// result output
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             kind,
	output logic [3:0]             channel_index,
	output logic [VAL_W-1:0]       channel_value,
	output logic                   frame_lost,
	output logic                   failsafe,
	output logic                   last
);

	logic [7:0]       header_q;
	logic [4:0]       pos_q, pos_n;
	logic [ACC_W-1:0] acc_q, acc_n;
	logic [4:0]       pend_q, pend_n;
	logic [4:0]       nch_q, nch_n;
	logic             rej_q, rej_n;

	result_t          res;
	logic             res_v;
	result_t          out_q, skid_q;
	logic             out_v_q, skid_v_q;

	logic             in_accept;
	logic [4:0]       pos_e, pend_e, nch_e, pend_sum;
	logic [ACC_W-1:0] acc_e, acc_sum;
	logic             rej_e;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_v_q;
	assign in_accept = in_valid && !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			header_q <= cfg_data;
		end
	end

	// frame start wipes the frame state before the byte is looked at
	always_comb begin
		pos_e  = frame_start ? POS_HEADER : pos_q;
		acc_e  = frame_start ? '0 : acc_q;
		pend_e = frame_start ? '0 : pend_q;
		nch_e  = frame_start ? '0 : nch_q;
		rej_e  = frame_start ? 1'b0 : rej_q;
		acc_sum  = acc_e | ACC_W'({10'd0, data_byte} << pend_e[3:0]);
		pend_sum = pend_e + BYTE_BITS;
	end

	always_comb begin
		pos_n  = pos_e;
		acc_n  = acc_e;
		pend_n = pend_e;
		nch_n  = nch_e;
		rej_n  = rej_e;
		res    = '0;
		res_v  = 1'b0;
		if (pos_e < POS_IDLE) begin
			pos_n = pos_e + 5'd1;
			if (!rej_e) begin
				if (pos_e == POS_HEADER) begin
					if (data_byte != header_q) begin
						rej_n    = 1'b1;
						res.kind = KIND_BAD_HDR;
						res.last = 1'b1;
						res_v    = 1'b1;
					end
				end else if (pos_e < POS_FLAGS) begin
					acc_n  = acc_sum;
					pend_n = pend_sum;
					if (pend_sum >= CH_BITS) begin
						acc_n  = acc_sum >> CH_BITS;
						pend_n = pend_sum - CH_BITS;
						if (nch_e < 5'(CHANNEL_COUNT)) begin
							res.kind          = KIND_CHANNEL;
							res.channel_index = nch_e[3:0];
							res.channel_value = acc_sum[VAL_W-1:0];
							res_v             = 1'b1;
						end
						if (nch_e < 5'd16) begin
							nch_n = nch_e + 5'd1;
						end
					end
				end else if (pos_e == POS_FLAGS) begin
					res.kind       = KIND_STATUS;
					res.frame_lost = data_byte[FLAG_LOST];
					res.failsafe   = data_byte[FLAG_FS];
					res.last       = 1'b1;
					res_v          = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_IDLE;
			acc_q  <= '0;
			pend_q <= '0;
			nch_q  <= '0;
			rej_q  <= 1'b0;
		end else if (in_accept) begin
			pos_q  <= pos_n;
			acc_q  <= acc_n;
			pend_q <= pend_n;
			nch_q  <= nch_n;
			rej_q  <= rej_n;
		end
	end

	// result register with skid: a new beat lands in the skid only while out is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !out_stall) begin
			out_v_q  <= skid_v_q || (in_accept && res_v);
			skid_v_q <= 1'b0;
		end else if (in_accept && res_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !out_stall) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (in_accept && res_v) begin
			skid_q <= res;
		end
	end

	assign out_valid     = out_v_q;
	assign kind          = out_q.kind;
	assign channel_index = out_q.channel_index;
	assign channel_value = out_q.channel_value;
	assign frame_lost    = out_q.frame_lost;
	assign failsafe      = out_q.failsafe;
	assign last          = out_q.last;

endmodule

// ===== design/sbusdf_checker.sv =====
// sbusdf_checker: port-level assertions for sbus_channel_deframer, plus its bind
// depends on sbusdf_pkg

module sbusdf_checker import sbusdf_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [1:0]       kind,
	input logic [3:0]       channel_index,
	input logic [VAL_W-1:0] channel_value,
	input logic             frame_lost,
	input logic             failsafe,
	input logic             last
);

	// a held result beat keeps its kind, index, value and last
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(channel_index)
			&& $stable(channel_value) && $stable(last))
		else $error("result beat changed while stalled");

	// input backpressure only once the result register is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind != KIND_CHANNEL)))
		else $error("last does not match result kind");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_CHANNEL || kind == KIND_STATUS || kind == KIND_BAD_HDR))
		else $error("undefined result kind");

	// only channel beats carry index and value; only status beats carry flags
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_CHANNEL |-> channel_index == 4'd0 && channel_value == '0
			&& (kind == KIND_STATUS || (!frame_lost && !failsafe)))
		else $error("unused result fields not zero");

endmodule

bind sbus_channel_deframer sbusdf_checker u_sbusdf_checker (.*);
